>>> rtl/i4dq_pkg.sv
package i4dq_pkg;

    localparam int NIB_W   = 4;
    localparam int LANE_N  = 8;
    localparam int HALF_W  = 16;

    // register indexes
    localparam logic [0:0] REG_FLOAT_FORMAT = 1'b0;

    // interleave order of the nibbles over the lanes
    typedef logic [2:0] nib_sel_t;
    localparam nib_sel_t LANE_ORDER [LANE_N] = '{
        3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7
    };

    // per lane stage 1 result: product and special-case info
    typedef struct packed {
        logic        sgn;
        logic        special;     // result fixed by special case
        logic [15:0] spec_bits;
        logic [14:0] prod;        // up to 11 x 4 bits
        logic        bf;
        logic        subn;        // scale exponent field was zero
        logic [7:0]  ef;
    } lane_mid_t;

endpackage

>>> rtl/int4_group_dequantize.sv
// int4 group dequantizer: eight lanes subtract a 4-bit zero point from a 4-bit
// weight (nibbles taken in the order 0,4,1,5,2,6,3,7) and multiply by a per-lane
// fp16 or bfloat16 scale, rounding to nearest even. one item per cycle while m_ready
// holds; a result passes the lane multiply register, then the output register. float_format is
// register 0 at address 0 of the apb port.
module int4_group_dequantize (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_packed_weights,
    input  logic [31:0] s_packed_zeros,
    input  logic [15:0] s_scale_0, s_scale_1, s_scale_2, s_scale_3,
    input  logic [15:0] s_scale_4, s_scale_5, s_scale_6, s_scale_7,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_value_0, m_value_1, m_value_2, m_value_3,
    output logic [15:0] m_value_4, m_value_5, m_value_6, m_value_7
);
    import i4dq_pkg::*;

    logic fmt_reg;
    logic v1_reg, v2_reg;
    logic adv1, adv2;
    logic [15:0] scl [LANE_N];
    logic [15:0] val [LANE_N];
    logic [15:0] out_reg [LANE_N];

    assign pready = 1'b1;
    assign prdata = {31'd0, fmt_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) fmt_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 2'd0) fmt_reg <= pwdata[0];
    end

    // two-stage pipe, each stage moves when the one after is free
    assign adv2    = v1_reg && (!v2_reg || m_ready);
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= 1'b1;
            else if (m_ready) v2_reg <= 1'b0;
        end
    end

    assign scl = '{s_scale_0, s_scale_1, s_scale_2, s_scale_3,
                   s_scale_4, s_scale_5, s_scale_6, s_scale_7};

    for (genvar i = 0; i < LANE_N; i++) begin : g_lane
        i4dq_lane u_lane (
            .aclk   (aclk),
            .en     (adv1),
            .weight (s_packed_weights[NIB_W*LANE_ORDER[i] +: NIB_W]),
            .zero   (s_packed_zeros[NIB_W*LANE_ORDER[i] +: NIB_W]),
            .scale  (scl[i]),
            .bf     (fmt_reg),
            .value  (val[i])
        );
        always_ff @(posedge aclk) begin
            if (adv2) out_reg[i] <= val[i];
        end
    end

    assign m_valid   = v2_reg;
    assign m_value_0 = out_reg[0];
    assign m_value_1 = out_reg[1];
    assign m_value_2 = out_reg[2];
    assign m_value_3 = out_reg[3];
    assign m_value_4 = out_reg[4];
    assign m_value_5 = out_reg[5];
    assign m_value_6 = out_reg[6];
    assign m_value_7 = out_reg[7];

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_0)) else $error("output changed");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && !m_ready |-> !s_ready) else $error("ready while full");
    a_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        adv2 |=> m_valid) else $error("result lost");
`endif
endmodule

>>> rtl/i4dq_lane.sv
module i4dq_lane (
    input  logic                aclk,
    input  logic                en,
    input  logic [3:0]          weight,
    input  logic [3:0]          zero,
    input  logic [15:0]         scale,
    input  logic                bf,
    output logic [15:0]         value
);
    import i4dq_pkg::*;

    lane_mid_t mid_next;
    lane_mid_t mid_reg;

    logic signed [4:0] diff;
    logic [3:0]  mag;
    logic [7:0]  ef;
    logic [9:0]  mf;
    logic        ef_max;
    logic [10:0] sig;

    always_comb begin
        diff = $signed({1'b0, weight}) - $signed({1'b0, zero});
        mag  = diff[4] ? 4'(-diff) : diff[3:0];
        if (bf) begin
            ef     = scale[14:7];
            mf     = {3'b0, scale[6:0]};
            ef_max = &scale[14:7];
        end else begin
            ef     = {3'b0, scale[14:10]};
            mf     = scale[9:0];
            ef_max = &scale[14:10];
        end
        sig = (ef == 8'd0) ? {1'b0, mf} : (bf ? {3'b0, 1'b1, mf[6:0]} : {1'b1, mf});
        mid_next.sgn       = scale[15] ^ diff[4];
        mid_next.bf        = bf;
        mid_next.subn      = (ef == 8'd0);
        mid_next.ef        = ef;
        mid_next.prod      = 15'(sig) * 15'(mag);
        mid_next.special   = ef_max;
        mid_next.spec_bits = 16'd0;
        if (ef_max) begin
            if (mf != 10'd0)
                mid_next.spec_bits = bf ? (scale | 16'h0040) : (scale | 16'h0200);
            else if (mag == 4'd0)
                mid_next.spec_bits = bf ? 16'h7FC0 : 16'h7E00;
            else
                mid_next.spec_bits = bf ? {mid_next.sgn, 15'h7F80}
                                        : {mid_next.sgn, 15'h7C00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) mid_reg <= mid_next;
    end

    // normalize and round; exponent math in biased-exponent units
    logic [3:0]         msb;
    logic signed [10:0] eb;      // biased exponent of the scale, 1 for a subnormal scale
    logic signed [10:0] sh;
    logic [4:0]         mb;
    logic [8:0]         emax;
    logic [15:0]        r;
    logic [15:0]        rem;
    logic [15:0]        half;
    logic [16:0]        bits;
    logic [3:0]         shu;

    always_comb begin
        mb   = mid_reg.bf ? 5'd7 : 5'd10;
        emax = mid_reg.bf ? 9'd255 : 9'd31;
        msb  = 4'd0;
        for (int k = 0; k < 15; k++)
            if (mid_reg.prod[k]) msb = 4'(k);
        // value = prod * 2^(E - bias - mb), E = ef or 1 for subnormal
        // result field exp = E + msb - mb, shift = msb - mb, clamp at E+shift>=1
        eb = mid_reg.subn ? 11'sd1 : $signed({3'b0, mid_reg.ef});
        sh = $signed({7'b0, msb}) - $signed({6'b0, mb});
        if (eb + sh < 11'sd1) sh = 11'sd1 - eb;
        r = 16'd0; rem = 16'd0; half = 16'd0; shu = 4'd0;
        if (sh <= 0) begin
            shu = 4'(-sh);
            r = 16'({1'b0, mid_reg.prod} << shu);
        end else begin
            shu  = (sh > 11'sd15) ? 4'd15 : 4'(sh);
            r    = 16'({1'b0, mid_reg.prod} >> shu);
            rem  = 16'({1'b0, mid_reg.prod}) & ((16'd1 << shu) - 16'd1);
            half = 16'd1 << (shu - 4'd1);
            if (rem > half || (rem == half && r[0])) r = r + 16'd1;
        end
        // field: (E+sh-1) << mb + r, where r includes hidden bit
        bits = (17'($unsigned(eb + sh - 11'sd1)) << mb) + 17'(r);
        if (bits >= 17'({emax, 10'b0} >> (5'd10 - mb))) bits = 17'({emax, 10'b0} >> (5'd10 - mb));
        if (mid_reg.special)
            value = mid_reg.spec_bits;
        else if (mid_reg.prod == 15'd0)
            value = {mid_reg.sgn, 15'd0};
        else
            value = {mid_reg.sgn, bits[14:0]};
    end
endmodule

>>> tb/int4_group_dequantize_tb.sv
module int4_group_dequantize_tb;
    import i4dq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic {FMT_FP16 = 1'b0, FMT_BF16 = 1'b1} fmt_t;

    typedef struct {
        logic [31:0] weights;
        logic [31:0] zeros;
        logic [15:0] scale [LANE_N];
    } dq_item_t;

    typedef struct {
        logic [15:0] value [LANE_N];
    } dq_result_t;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic [31:0] s_packed_weights, s_packed_zeros;
    logic [15:0] s_scale [LANE_N];
    logic        m_valid, m_ready;
    logic [15:0] m_value [LANE_N];

    fmt_t        cur_fmt;
    dq_result_t  expected_values [$];
    int          err_count;
    int          idle_cycles;
    bit          hold_ready_high;

    int_dq_dummy_guard: assert property (@(posedge aclk) 1);

    int4_group_dequantize dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_packed_weights(s_packed_weights), .s_packed_zeros(s_packed_zeros),
        .s_scale_0(s_scale[0]), .s_scale_1(s_scale[1]), .s_scale_2(s_scale[2]),
        .s_scale_3(s_scale[3]), .s_scale_4(s_scale[4]), .s_scale_5(s_scale[5]),
        .s_scale_6(s_scale[6]), .s_scale_7(s_scale[7]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value_0(m_value[0]), .m_value_1(m_value[1]), .m_value_2(m_value[2]),
        .m_value_3(m_value[3]), .m_value_4(m_value[4]), .m_value_5(m_value[5]),
        .m_value_6(m_value[6]), .m_value_7(m_value[7])
    );

    always #10 aclk = ~aclk;

    // one lane: (w - z) * scale, exact product then a single round to nearest even
    function automatic logic [15:0] scaled_lane(logic [3:0] w, logic [3:0] z,
                                                logic [15:0] s, fmt_t fmt);
        int          mb, eb, bias, minq, d, e, n, shift, q;
        logic [31:0] emax, mag, sgn, ef, mf, p, r, rem, half, bits;
        mb   = (fmt == FMT_BF16) ? 7 : 10;
        eb   = (fmt == FMT_BF16) ? 8 : 5;
        bias = (fmt == FMT_BF16) ? 127 : 15;
        emax = (32'd1 << eb) - 1;
        minq = 1 - bias - mb;
        d    = int'(w) - int'(z);
        mag  = (d < 0) ? -d : d;
        sgn  = (s & 32'h8000) ^ ((d < 0) ? 32'h8000 : 0);
        ef   = (s >> mb) & emax;
        mf   = s & ((32'd1 << mb) - 1);
        if (ef == emax) begin
            // nan keeps sign and payload, infinity times zero is the quiet nan
            if (mf != 0) return 16'(s | (32'd1 << (mb - 1)));
            if (mag == 0) return (fmt == FMT_BF16) ? 16'h7FC0 : 16'h7E00;
            return 16'(sgn | (emax << mb));
        end
        if (ef == 0) begin
            p = mf;
            e = minq;
        end else begin
            p = mf | (32'd1 << mb);
            e = int'(ef) - bias - mb;
        end
        p = p * mag;
        if (p == 0) return 16'(sgn);
        n = 0;
        while ((p >> (n + 1)) != 0) n++;
        shift = n - mb;
        if (minq - e > shift) shift = minq - e;
        if (shift <= 0) begin
            r = p << (-shift);
        end else begin
            rem  = p & ((32'd1 << shift) - 1);
            half = 32'd1 << (shift - 1);
            r    = p >> shift;
            if (rem > half || (rem == half && r[0])) r++;
        end
        q = e + shift;
        if (r >= (32'd2 << mb)) begin
            r = r >> 1;
            q++;
        end
        bits = (32'(q - minq) << mb) + r;
        // overflow saturates to infinity
        if (bits >= (emax << mb)) bits = emax << mb;
        return 16'(sgn | bits);
    endfunction

    function automatic dq_result_t dequantize_item(dq_item_t it, fmt_t fmt);
        dq_result_t res;
        int         sh;
        for (int i = 0; i < LANE_N; i++) begin
            sh = NIB_W * int'(LANE_ORDER[i]);
            res.value[i] = scaled_lane(it.weights[sh +: 4], it.zeros[sh +: 4],
                                       it.scale[i], fmt);
        end
        return res;
    endfunction

    // apb write: setup cycle then access cycle
    task automatic write_reg(logic [1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // waits for the pipe to drain, then switches format; only bit 0 counts
    task automatic set_format(fmt_t fmt, logic [30:0] junk);
        wait (expected_values.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(2'(REG_FLOAT_FORMAT) * 2'd0, {junk, fmt});
        cur_fmt = fmt;
    endtask

    // sends one item, with a random gap before it; valid may stay high back to back
    task automatic send_item(dq_item_t it, bit allow_gap = 1'b1);
        int gap;
        gap = allow_gap ? $urandom_range(0, 10) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_packed_weights <= it.weights;
        s_packed_zeros   <= it.zeros;
        for (int i = 0; i < LANE_N; i++) s_scale[i] <= it.scale[i];
        do @(posedge aclk); while (!s_ready);
        expected_values.push_back(dequantize_item(it, cur_fmt));
    endtask

    // drop valid and wait for a clock edge so the next driver starts on a fresh cycle
    task automatic end_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_scale(fmt_t fmt);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return (fmt == FMT_BF16) ? 16'h7F80 : 16'h7C00;   // infinity
        if (pick == 1) return 16'($urandom_range(0, 15));                // subnormal, tiny
        if (pick == 2) return {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                               (fmt == FMT_BF16) ? 15'h7F7F : 15'h7BFF}; // near max
        return 16'($urandom());
    endfunction

    function automatic dq_item_t rand_item(fmt_t fmt);
        dq_item_t it;
        it.weights = $urandom();
        it.zeros   = ($urandom_range(0, 4) == 0) ? it.weights : $urandom();
        for (int i = 0; i < LANE_N; i++) it.scale[i] = rand_scale(fmt);
        return it;
    endfunction

    function automatic dq_item_t fill_item(logic [31:0] w, logic [31:0] z, logic [15:0] s);
        dq_item_t it;
        it.weights = w;
        it.zeros   = z;
        for (int i = 0; i < LANE_N; i++) it.scale[i] = s;
        return it;
    endfunction

    // extremes of the fields and every special case, in one format
    task automatic test_directed(fmt_t fmt);
        logic [15:0] inf_s, nan_s, max_s, one_s;
        dq_item_t    it;
        inf_s = (fmt == FMT_BF16) ? 16'h7F80 : 16'h7C00;
        nan_s = (fmt == FMT_BF16) ? 16'hFF81 : 16'hFC01;
        max_s = (fmt == FMT_BF16) ? 16'h7F7F : 16'h7BFF;
        one_s = (fmt == FMT_BF16) ? 16'h3F80 : 16'h3C00;
        send_item(fill_item(32'h0000_0000, 32'h0000_0000, 16'hFFFF));
        send_item(fill_item(32'hFFFF_FFFF, 32'h0000_0000, one_s));      // d = +15
        send_item(fill_item(32'h0000_0000, 32'hFFFF_FFFF, one_s));      // d = -15
        send_item(fill_item(32'h7654_3210, 32'h0000_0000, one_s));      // interleave order
        send_item(fill_item(32'h89AB_CDEF, 32'h0123_4567, 16'h8000));   // negative zero scale
        send_item(fill_item(32'h5555_5555, 32'h5555_5555, 16'hC123));   // zero difference
        send_item(fill_item(32'hF0F0_F0F0, 32'h0F0F_0F0F, nan_s));      // nan kept
        send_item(fill_item(32'h1234_5678, 32'h1234_5678, inf_s));      // inf times zero
        send_item(fill_item(32'hFFFF_FFFF, 32'h1111_1111, inf_s));      // signed infinity
        send_item(fill_item(32'hFFFF_FFFF, 32'h0000_0000, max_s));      // overflow
        send_item(fill_item(32'hFFFF_FFFF, 32'h0000_0000, 16'h0001));   // subnormal
        send_item(fill_item(32'h3333_3333, 32'h0000_0000, 16'h83FF));   // subnormal rounding (fp16)
        send_item(fill_item(32'h9999_9999, 32'h2222_2222, 16'h7FFF));   // nan, all ones
        it = fill_item(32'hFEDC_BA98, 32'h7654_3210, one_s);
        for (int i = 0; i < LANE_N; i++) it.scale[i] = 16'(one_s + i * 16'h0101);
        send_item(it, 1'b0);
        end_burst();
    endtask

    task automatic test_random(int count);
        repeat (count) send_item(rand_item(cur_fmt));
        end_burst();
    endtask

    // result side: random stall per item, with stretches of no stall
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = hold_ready_high ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // checks each result against the oldest expectation
    always @(posedge aclk) begin
        dq_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_values.size() == 0) begin
                $error("result with no expectation waiting");
                err_count++;
            end else begin
                want = expected_values.pop_front();
                for (int i = 0; i < LANE_N; i++) begin
                    if (m_value[i] !== want.value[i]) begin
                        $error("value_%0d expected %h actual %h", i, want.value[i], m_value[i]);
                        err_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        aclk             = 1'b0;
        aresetn          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        s_valid          = 1'b0;
        s_packed_weights = '0;
        s_packed_zeros   = '0;
        for (int i = 0; i < LANE_N; i++) s_scale[i] = '0;
        cur_fmt          = FMT_FP16;
        err_count        = 0;
        idle_cycles      = 0;
        hold_ready_high  = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value of the format register is fp16
        test_directed(FMT_FP16);
        test_random(300);
        set_format(FMT_BF16, 31'h2AAA_AAAA);
        test_directed(FMT_BF16);
        test_random(300);
        set_format(FMT_FP16, 31'h7FFF_FFFF);
        hold_ready_high = 1'b1;
        test_random(200);
        hold_ready_high = 1'b0;
        set_format(FMT_BF16, 31'h0);
        test_random(300);
        set_format(FMT_FP16, 31'h5555_5555);
        test_random(200);

        wait (expected_values.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && expected_values.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
